>>> src/btg_pkg.sv
`default_nettype none

package btg_pkg;

  localparam int PHASE_W = 32;
  localparam int COUNT_WIDTH = 24;
  localparam int REG_W = 24;
  localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
  localparam int AMP_W = 15;
  localparam int SAMPLE_W = 16;
  localparam int SINE_W = 15;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int TBL_IDX_W = SINE_IDX_W + 1;
  localparam int PHASE_KEEP = SINE_IDX_W + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] SINE_MAX = 64'd32767;
  localparam logic [PHASE_W:0] PHASE_PI = {2'b01, {(PHASE_W - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_STEP  = 3'd0,
    REG_ENVELOPE_STEP = 3'd1,
    REG_BURST_PERIOD  = 3'd2,
    REG_BURST_LENGTH  = 3'd3,
    REG_AMPLITUDE     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic restart;
    logic last_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_out;
  } out_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] carrier_step;
    logic [PHASE_W-1:0] envelope_step;
    logic [REG_W-1:0]   burst_period;
    logic [REG_W-1:0]   burst_length;
    logic [AMP_W-1:0]   amplitude;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_KEEP-1:0] carrier_top;
    logic [PHASE_KEEP-1:0] envelope_top;
    logic                  active;
    logic                  last;
  } job_t;

  typedef logic [SINE_W-1:0] quarter_table_t [0:SINE_TABLE_DEPTH];

  function automatic quarter_table_t build_quarter_table();
    quarter_table_t     t;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = (PI_HALF_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      term = x;
      sum = $signed(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      if (sum > $signed(ONE_Q30)) begin
        sum = $signed(ONE_Q30);
      end
      r = ($unsigned(sum) * SINE_MAX + (ONE_Q30 >> 1)) >> 30;
      if (r > SINE_MAX) begin
        r = SINE_MAX;
      end
      t[i] = r[SINE_W-1:0];
    end
    return t;
  endfunction

  localparam quarter_table_t QUARTER_TABLE = build_quarter_table();

  function automatic logic [SINE_W-1:0] sine_mag(input logic [PHASE_KEEP-1:0] p);
    logic [TBL_IDX_W-1:0] k;
    logic [TBL_IDX_W-1:0] idx;
    k = {1'b0, p[SINE_IDX_W-1:0]};
    if (p[PHASE_KEEP-2]) begin
      idx = TBL_IDX_W'(SINE_TABLE_DEPTH) - k;
    end else begin
      idx = k;
    end
    return QUARTER_TABLE[idx];
  endfunction

endpackage

`default_nettype wire

>>> src/burst_tone_generator_top.sv
`default_nettype none

// Burst tone generator: every tick transaction produces one signed 16-bit sample, the
// carrier sine times a half-sine burst envelope times the programmed amplitude. The
// front end updates the phase accumulators and burst counter in the cycle a tick is
// taken and places the job in a four-entry queue; the back end looks up both sines
// and applies two registered multiplies, so one sample per cycle is sustained when
// the result is not stalled. The result passes the sine lookup, the two multiplies
// and the output register. The user must write registers through the configuration
// port only while no transaction is in flight; the block does not enforce this.
module burst_tone_generator_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              tick_valid,
  output logic                                   tick_stall,
  input  wire btg_pkg::in_item_t                 tick,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output btg_pkg::out_item_t                     result,
  input  wire logic                              cfg_write,
  input  wire logic [btg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [btg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import btg_pkg::*;

  cfg_t cfg;
  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic job_valid;
  job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_step <= PHASE_W'(40265318);
      cfg.envelope_step <= PHASE_W'(167772);
      cfg.burst_period <= REG_W'(48000);
      cfg.burst_length <= REG_W'(12800);
      cfg.amplitude <= AMP_W'(8000);
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_CARRIER_STEP:  cfg.carrier_step <= cfg_data[PHASE_W-1:0];
        REG_ENVELOPE_STEP: cfg.envelope_step <= cfg_data[PHASE_W-1:0];
        REG_BURST_PERIOD:  cfg.burst_period <= cfg_data[REG_W-1:0];
        REG_BURST_LENGTH:  cfg.burst_length <= cfg_data[REG_W-1:0];
        REG_AMPLITUDE:     cfg.amplitude <= cfg_data[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  btg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick       (tick),
    .cfg        (cfg),
    .queue_full (queue_full),
    .tick_stall (tick_stall),
    .push       (push),
    .push_job   (push_job)
  );

  btg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (queue_full),
    .job_valid (job_valid),
    .job       (job)
  );

  btg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job          (job),
    .amplitude    (cfg.amplitude),
    .result_stall (result_stall),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> src/btg_front.sv
`default_nettype none

module btg_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tick_valid,
  input  wire btg_pkg::in_item_t tick,
  input  wire btg_pkg::cfg_t    cfg,
  input  wire logic             queue_full,
  output logic                  tick_stall,
  output logic                  push,
  output btg_pkg::job_t         push_job
);
  import btg_pkg::*;

  logic [PHASE_W-1:0]     carrier_phase;
  logic [PHASE_W-1:0]     envelope_phase;
  logic [COUNT_WIDTH-1:0] burst_count;

  logic [PHASE_W-1:0]     carrier_phase_next;
  logic [PHASE_W-1:0]     envelope_phase_next;
  logic [COUNT_WIDTH-1:0] burst_count_next;

  logic [PHASE_W-1:0]     p0;
  logic [PHASE_W-1:0]     e0;
  logic [PHASE_W-1:0]     e1;
  logic [COUNT_WIDTH-1:0] c0;
  logic [COUNT_WIDTH-1:0] c1;
  logic                   wrap;
  logic                   active;
  logic [PHASE_W:0]       env_sum;

  assign tick_stall = queue_full;
  assign push = tick_valid && !queue_full;

  always_comb begin
    p0 = tick.restart ? '0 : carrier_phase;
    e0 = tick.restart ? '0 : envelope_phase;
    c0 = tick.restart ? '0 : burst_count;
    c1 = c0 + COUNT_WIDTH'(1);
    wrap = CMP_W'(c1) >= CMP_W'(cfg.burst_period);
    burst_count_next = wrap ? '0 : c1;
    e1 = wrap ? '0 : e0;
    active = CMP_W'(burst_count_next) < CMP_W'(cfg.burst_length);
    env_sum = {1'b0, e1} + {1'b0, cfg.envelope_step};
    if (!active) begin
      envelope_phase_next = e1;
    end else if (env_sum >= PHASE_PI) begin
      envelope_phase_next = PHASE_PI[PHASE_W-1:0];
    end else begin
      envelope_phase_next = env_sum[PHASE_W-1:0];
    end
    carrier_phase_next = p0 + cfg.carrier_step;
    push_job.carrier_top = carrier_phase_next[PHASE_W-1 -: PHASE_KEEP];
    push_job.envelope_top = e1[PHASE_W-1 -: PHASE_KEEP];
    push_job.active = active;
    push_job.last = tick.last_of_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase <= '0;
      envelope_phase <= '0;
      burst_count <= '0;
    end else if (push) begin
      carrier_phase <= carrier_phase_next;
      envelope_phase <= envelope_phase_next;
      burst_count <= burst_count_next;
    end
  end

endmodule

`default_nettype wire

>>> src/btg_queue.sv
`default_nettype none

module btg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire btg_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               job_valid,
  output btg_pkg::job_t      job
);
  import btg_pkg::*;

  job_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign job_valid = (count != '0);
  assign job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> src/btg_back.sv
`default_nettype none

module btg_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          job_valid,
  input  wire btg_pkg::job_t                 job,
  input  wire logic [btg_pkg::AMP_W-1:0]     amplitude,
  input  wire logic                          result_stall,
  output logic                               pop,
  output logic                               result_valid,
  output btg_pkg::out_item_t                 result
);
  import btg_pkg::*;

  localparam int PROD1_W = 2 * SINE_W;
  localparam int PROD2_W = PROD1_W + AMP_W;

  logic                    advance;
  logic                    a_valid;
  logic                    b_valid;
  logic                    c_valid;
  logic [SINE_W-1:0]       a_carrier;
  logic [SINE_W-1:0]       a_env;
  logic                    a_neg;
  logic                    a_last;
  logic [PROD1_W-1:0]      b_prod;
  logic                    b_neg;
  logic                    b_last;
  logic [PROD2_W-1:0]      c_prod;
  logic                    c_neg;
  logic                    c_last;
  logic [SAMPLE_W-1:0]     mag;

  assign advance = !result_valid || !result_stall;
  assign pop = advance && job_valid;
  assign mag = {1'b0, c_prod[PROD2_W-1 -: SINE_W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= job_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      result_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_carrier <= sine_mag(job.carrier_top);
      a_env <= job.active ? sine_mag(job.envelope_top) : '0;
      a_neg <= job.carrier_top[PHASE_KEEP-1];
      a_last <= job.last;
      b_prod <= PROD1_W'(a_carrier) * PROD1_W'(a_env);
      b_neg <= a_neg;
      b_last <= a_last;
      c_prod <= PROD2_W'(b_prod) * PROD2_W'(amplitude);
      c_neg <= b_neg;
      c_last <= b_last;
      result.sample <= c_neg ? $signed(-mag) : $signed(mag);
      result.last_out <= c_last;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_burst_tone_generator_top.sv
`timescale 1ns / 1ps

import btg_pkg::*;

class tone_checker;
  logic [SINE_W-1:0] quarter [0:SINE_TABLE_DEPTH];
  logic [31:0]       carrier_step;
  logic [31:0]       envelope_step;
  logic [23:0]       burst_period;
  logic [23:0]       burst_length;
  logic [14:0]       amplitude;
  logic [31:0]       carrier_phase;
  logic [31:0]       envelope_phase;
  logic [23:0]       burst_count;
  out_item_t         pending_samples[$];
  int                mismatches;

  function new();
    longint unsigned x;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    // The quarter-wave table is a Taylor series in Q2.30, rounded to unsigned Q0.15.
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > 64'sd1073741824) begin
        sum = 64'sd1073741824;
      end
      r = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      quarter[i] = r[SINE_W-1:0];
    end
    mismatches = 0;
    carrier_step = 32'd40265318;
    envelope_step = 32'd167772;
    burst_period = 24'd48000;
    burst_length = 24'd12800;
    amplitude = 15'd8000;
    carrier_phase = '0;
    envelope_phase = '0;
    burst_count = '0;
  endfunction

  function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      REG_CARRIER_STEP:  carrier_step = data;
      REG_ENVELOPE_STEP: envelope_step = data;
      REG_BURST_PERIOD:  burst_period = data[23:0];
      REG_BURST_LENGTH:  burst_length = data[23:0];
      REG_AMPLITUDE:     amplitude = data[14:0];
      default: ;
    endcase
  endfunction

  function int phase_sine(input logic [31:0] p);
    logic [SINE_IDX_W-1:0] k;
    int                    v;
    k = p[29 -: SINE_IDX_W];
    if (p[30]) begin
      v = int'(quarter[SINE_TABLE_DEPTH - int'(k)]);
    end else begin
      v = int'(quarter[k]);
    end
    return p[31] ? -v : v;
  endfunction

  function void take_tick(input in_item_t t);
    int              env;
    int              sc;
    longint unsigned mag;
    logic [32:0]     next_env;
    out_item_t       due;
    env = 0;
    if (t.restart) begin
      carrier_phase = '0;
      envelope_phase = '0;
      burst_count = '0;
    end
    burst_count = burst_count + 24'd1;
    if (burst_count >= burst_period) begin
      burst_count = '0;
      envelope_phase = '0;
    end
    if (burst_count < burst_length) begin
      env = phase_sine(envelope_phase);
      next_env = {1'b0, envelope_phase} + {1'b0, envelope_step};
      if (next_env >= 33'h080000000) begin
        next_env = 33'h080000000;
      end
      envelope_phase = next_env[31:0];
    end
    carrier_phase = carrier_phase + carrier_step;
    sc = phase_sine(carrier_phase);
    mag = 64'(sc < 0 ? -sc : sc) * 64'(env) * 64'(amplitude);
    mag = mag >> 30;
    due.sample = (sc < 0) ? -16'(mag) : 16'(mag);
    due.last_out = t.last_of_block;
    pending_samples.push_back(due);
  endfunction

  function void check_sample(input out_item_t got);
    out_item_t due;
    if (pending_samples.size() == 0) begin
      $error("unexpected sample %0d, last_out %0b", got.sample, got.last_out);
      mismatches++;
      return;
    end
    due = pending_samples.pop_front();
    if (got.sample !== due.sample) begin
      $error("sample: expected %0d, got %0d", due.sample, got.sample);
      mismatches++;
    end
    if (got.last_out !== due.last_out) begin
      $error("last_out: expected %0b, got %0b", due.last_out, got.last_out);
      mismatches++;
    end
  endfunction
endclass

module tb_burst_tone_generator_top;
  localparam int QUIET_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  tick_valid = 1'b0;
  logic                  tick_stall;
  in_item_t              tick = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_item_t             result;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tone_checker board = new();
  bit          idling = 1'b1;
  bit          tick_taken = 1'b0;
  int          quiet_cycles = 0;

  burst_tone_generator_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= idling && ($urandom_range(0, 99) < 17);
  end

  // Inputs only change at the rising edge, so the falling edge sees what the next edge takes.
  always @(negedge clk) begin
    tick_taken = 1'b0;
    if (!rst) begin
      if (cfg_write) begin
        board.write_reg(cfg_index, cfg_data);
      end
      tick_taken = tick_valid && !tick_stall;
      if (tick_taken) begin
        board.take_tick(tick);
      end
      if (result_valid && !result_stall) begin
        board.check_sample(result);
        quiet_cycles = 0;
      end else if (tick_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb_burst_tone_generator_top: done, errors");
    $finish;
  end

  task automatic send_tick(input bit restart, input bit last_of_block);
    while (idling && $urandom_range(0, 99) < 17) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= '{restart: restart, last_of_block: last_of_block};
    @(posedge clk);
    while (!tick_taken) @(posedge clk);
  endtask

  task automatic drain();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data,
                           input bit hold);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (!hold) begin
      cfg_write <= 1'b0;
    end
  endtask

  task automatic configure(input logic [31:0] cs, input logic [31:0] es,
                           input logic [23:0] bp, input logic [23:0] bl,
                           input logic [14:0] amp);
    drain();
    write_cfg(CFG_IDX_W'($urandom_range(int'(REG_AMPLITUDE) + 1, (1 << CFG_IDX_W) - 1)),
              $urandom, 1'b1);
    write_cfg(REG_CARRIER_STEP, cs, 1'b1);
    write_cfg(REG_ENVELOPE_STEP, es, 1'b1);
    write_cfg(REG_BURST_PERIOD, {8'($urandom), bp}, 1'b1);
    write_cfg(REG_BURST_LENGTH, {8'($urandom), bl}, 1'b1);
    write_cfg(REG_AMPLITUDE, {17'($urandom), amp}, 1'b0);
  endtask

  task automatic random_phase(input int items, input bit pause_midway);
    logic [31:0] cs;
    logic [31:0] es;
    logic [23:0] bp;
    logic [23:0] bl;
    logic [14:0] amp;
    case ($urandom_range(0, 9))
      0:       bp = 24'd0;
      1:       bp = 24'hFFFFFF;
      2:       bp = 24'($urandom);
      3, 4:    bp = 24'($urandom_range(1, 2000));
      default: bp = 24'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 7))
      0:       bl = 24'd0;
      1:       bl = 24'hFFFFFF;
      2:       bl = 24'($urandom);
      default: bl = 24'($urandom_range(0, (bp < 24'd120) ? int'(bp) + 2 : 120));
    endcase
    case ($urandom_range(0, 7))
      0:       es = 32'd0;
      1:       es = 32'h80000000;
      2:       es = 32'hFFFFFFFF;
      3:       es = $urandom;
      default: es = 32'((64'd1 << 31) / (64'(bl) + 64'd1) + 64'($urandom_range(0, 1 << 20)));
    endcase
    case ($urandom_range(0, 7))
      0:       cs = 32'd0;
      1:       cs = 32'hFFFFFFFF;
      2:       cs = 32'h40000000;
      default: cs = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       amp = 15'd0;
      1:       amp = 15'h7FFF;
      default: amp = 15'($urandom);
    endcase
    configure(cs, es, bp, bl, amp);
    for (int i = 0; i < items; i++) begin
      if (pause_midway && i == items / 2) begin
        drain();
      end
      send_tick($urandom_range(0, 99) < 3, 1'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);

    // Full scale with the burst length beyond the period; the third tick hits the positive peak.
    configure(32'hC0000000, 32'h20000000, 24'd5, 24'd8, 15'h7FFF);
    send_tick(1'b1, 1'b0);
    repeat (4) send_tick(1'b0, 1'($urandom));
    drain();
    write_cfg(REG_CARRIER_STEP, 32'h40000000, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);

    configure($urandom, 32'h10000000, 24'd0, 24'd5, 15'h7FFF);
    repeat (3) send_tick(1'b0, 1'($urandom));

    configure(32'h40000000, 32'hFFFFFFFF, 24'd16, 24'd16, 15'd20000);
    send_tick(1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'($urandom));

    // Shrinking the period below the running count forces a wrap on the next tick.
    configure(32'd40265318, 32'h04000000, 24'd100, 24'd50, 15'd12345);
    send_tick(1'b1, 1'b0);
    repeat (5) send_tick(1'b0, 1'($urandom));
    drain();
    write_cfg(REG_BURST_PERIOD, 32'd3, 1'b0);
    repeat (3) send_tick(1'b0, 1'($urandom));

    for (int p = 0; p < 14; p++) begin
      idling = (p != 3);
      random_phase(105, p == 7);
    end
    idling = 1'b1;

    drain();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending_samples.size() == 0) begin
      $display("tb_burst_tone_generator_top: done, clean");
    end else begin
      $display("tb_burst_tone_generator_top: done, errors");
    end
    $finish;
  end
endmodule
